[rtl/cicdd_pkg.sv]
`default_nettype none
package cicdd_pkg;

  typedef enum logic [1:0] {
    ACT_CLEAR   = 2'd0,
    ACT_DEPOSIT = 2'd1,
    ACT_READ    = 2'd2,
    ACT_NONE    = 2'd3
  } action_e;

  localparam logic [2:0] REG_CELLS_X = 3'd0;
  localparam logic [2:0] REG_CELLS_Y = 3'd1;
  localparam logic [2:0] REG_CELLS_Z = 3'd2;
  localparam logic [2:0] REG_INV_X   = 3'd3;
  localparam logic [2:0] REG_INV_Y   = 3'd4;
  localparam logic [2:0] REG_INV_Z   = 3'd5;

  localparam logic [16:0] UNIT_WEIGHT = 17'h10000;
  localparam int unsigned MOD_STEPS   = 8;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_CLR1,
    S_CLR2,
    S_SWEEP,
    S_RD,
    S_RD_OUT,
    S_DMUL,
    S_DMOD,
    S_DAXIS,
    S_CA,
    S_CB,
    S_CC,
    S_CD
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SWEEP,
    OP_CLR1,
    OP_CLR2,
    OP_RD,
    OP_MUL,
    OP_MOD,
    OP_AXIS,
    OP_CA,
    OP_CB,
    OP_CC,
    OP_CD
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic mod_last;
    logic axis_last;
    logic corner_last;
  } dp_status_t;

  function automatic logic [8:0] clamp_cells(input logic [8:0] n);
    logic [8:0] r;
    r = n;
    if (n == 9'd0) r = 9'd1;
    else if (n > 9'd256) r = 9'd256;
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/cicdd_ram.sv]
`default_nettype none
module cicdd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule
`default_nettype wire

[rtl/cicdd_ctrl.sv]
`default_nettype none
module cicdd_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [1:0]           action_i,
  input  wire logic [7:0]           color_i,
  input  wire cicdd_pkg::dp_status_t status_i,
  output cicdd_pkg::dp_cmd_t         cmd_o,
  output logic                      busy_o,
  output logic                      result_valid_o
);

  cicdd_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cicdd_pkg::S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      cicdd_pkg::S_INIT: begin
        if (status_i.sweep_last) state_d = cicdd_pkg::S_IDLE;
      end
      cicdd_pkg::S_IDLE: begin
        if (start_i) begin
          case (action_i)
            cicdd_pkg::ACT_CLEAR:   state_d = cicdd_pkg::S_CLR1;
            cicdd_pkg::ACT_DEPOSIT: begin
              if (color_i != 8'd0) state_d = cicdd_pkg::S_DMUL;
            end
            cicdd_pkg::ACT_READ:    state_d = cicdd_pkg::S_RD;
            default:                state_d = cicdd_pkg::S_IDLE;
          endcase
        end
      end
      cicdd_pkg::S_CLR1:   state_d = cicdd_pkg::S_CLR2;
      cicdd_pkg::S_CLR2:   state_d = cicdd_pkg::S_SWEEP;
      cicdd_pkg::S_SWEEP: begin
        if (status_i.sweep_last) state_d = cicdd_pkg::S_IDLE;
      end
      cicdd_pkg::S_RD:     state_d = cicdd_pkg::S_RD_OUT;
      cicdd_pkg::S_RD_OUT: state_d = cicdd_pkg::S_IDLE;
      cicdd_pkg::S_DMUL:   state_d = cicdd_pkg::S_DMOD;
      cicdd_pkg::S_DMOD: begin
        if (status_i.mod_last) state_d = cicdd_pkg::S_DAXIS;
      end
      cicdd_pkg::S_DAXIS: begin
        state_d = status_i.axis_last ? cicdd_pkg::S_CA : cicdd_pkg::S_DMUL;
      end
      cicdd_pkg::S_CA:     state_d = cicdd_pkg::S_CB;
      cicdd_pkg::S_CB:     state_d = cicdd_pkg::S_CC;
      cicdd_pkg::S_CC:     state_d = cicdd_pkg::S_CD;
      cicdd_pkg::S_CD: begin
        state_d = status_i.corner_last ? cicdd_pkg::S_IDLE : cicdd_pkg::S_CA;
      end
      default:             state_d = cicdd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op       = cicdd_pkg::OP_NONE;
    busy_o         = 1'b1;
    result_valid_o = 1'b0;
    case (state_q)
      cicdd_pkg::S_INIT:   cmd_o.op = cicdd_pkg::OP_SWEEP;
      cicdd_pkg::S_IDLE: begin
        busy_o = 1'b0;
        if (start_i) cmd_o.op = cicdd_pkg::OP_LOAD;
      end
      cicdd_pkg::S_CLR1:   cmd_o.op = cicdd_pkg::OP_CLR1;
      cicdd_pkg::S_CLR2:   cmd_o.op = cicdd_pkg::OP_CLR2;
      cicdd_pkg::S_SWEEP:  cmd_o.op = cicdd_pkg::OP_SWEEP;
      cicdd_pkg::S_RD:     cmd_o.op = cicdd_pkg::OP_RD;
      cicdd_pkg::S_RD_OUT: result_valid_o = 1'b1;
      cicdd_pkg::S_DMUL:   cmd_o.op = cicdd_pkg::OP_MUL;
      cicdd_pkg::S_DMOD:   cmd_o.op = cicdd_pkg::OP_MOD;
      cicdd_pkg::S_DAXIS:  cmd_o.op = cicdd_pkg::OP_AXIS;
      cicdd_pkg::S_CA:     cmd_o.op = cicdd_pkg::OP_CA;
      cicdd_pkg::S_CB:     cmd_o.op = cicdd_pkg::OP_CB;
      cicdd_pkg::S_CC:     cmd_o.op = cicdd_pkg::OP_CC;
      cicdd_pkg::S_CD:     cmd_o.op = cicdd_pkg::OP_CD;
      default:             cmd_o.op = cicdd_pkg::OP_NONE;
    endcase
  end

endmodule
`default_nettype wire

[rtl/cicdd_dp.sv]
`default_nettype none
module cicdd_dp #(
  parameter int CELL_INDEX_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire cicdd_pkg::dp_cmd_t     cmd_i,
  output cicdd_pkg::dp_status_t       status_o,
  input  wire logic [8:0]            cells_x_i,
  input  wire logic [8:0]            cells_y_i,
  input  wire logic [8:0]            cells_z_i,
  input  wire logic [31:0]           inv_x_i,
  input  wire logic [31:0]           inv_y_i,
  input  wire logic [31:0]           inv_z_i,
  input  wire logic [31:0]           pos_x_i,
  input  wire logic [31:0]           pos_y_i,
  input  wire logic [31:0]           pos_z_i,
  input  wire logic [15:0]           cell_index_i,
  output logic      [31:0]           density_o,
  output logic                       saturated_o
);

  localparam int DEPTH = 1 << CELL_INDEX_BITS;
  localparam logic [CELL_INDEX_BITS:0] FULL = {1'b1, {CELL_INDEX_BITS{1'b0}}};

  logic [CELL_INDEX_BITS:0]   cnt_q, limit_q;
  logic [CELL_INDEX_BITS-1:0] idx_q;
  logic [31:0]  pos_q [3];
  logic [1:0]   axis_q;
  logic [2:0]   step_q;
  logic [2:0]   corner_q;
  logic [31:0]  sh_q;
  logic [8:0]   rem_q;
  logic [15:0]  frac_q [3];
  logic [7:0]   base_q [3];
  logic [7:0]   hi_q [3];
  logic [16:0]  nxy_q;
  logic [16:0]  p1_q;
  logic [33:0]  wxy_q;
  logic [16:0]  w_q;
  logic         sat_q;

  logic [8:0]   nx, ny, nz, nsel;
  logic [31:0]  inv_sel;
  logic [63:0]  prod;
  logic [8:0]   r;
  logic [9:0]   r10;
  logic [31:0]  sh;
  logic [8:0]   rem_inc;
  logic [7:0]   xs, ys, zs;
  logic [16:0]  wx, wy, wz;
  logic [16:0]  t;
  logic [25:0]  idx_full;
  logic [50:0]  wprod;
  logic [24:0]  count;
  logic [32:0]  sum;
  logic         we;
  logic [CELL_INDEX_BITS-1:0] addr;
  logic [31:0]  wdata;
  logic [31:0]  rdata;

  assign nx = cicdd_pkg::clamp_cells(cells_x_i);
  assign ny = cicdd_pkg::clamp_cells(cells_y_i);
  assign nz = cicdd_pkg::clamp_cells(cells_z_i);

  always_comb begin
    case (axis_q)
      2'd0:    begin nsel = nx; inv_sel = inv_x_i; end
      2'd1:    begin nsel = ny; inv_sel = inv_y_i; end
      default: begin nsel = nz; inv_sel = inv_z_i; end
    endcase
  end

  assign prod = {32'd0, pos_q[axis_q]} * {32'd0, inv_sel};

  // four remainder bits per cycle
  always_comb begin
    r  = rem_q;
    sh = sh_q;
    r10 = '0;
    for (int k = 0; k < 4; k++) begin
      r10 = {r, sh[31]};
      sh  = sh << 1;
      if (r10 >= {1'b0, nsel}) r10 = r10 - {1'b0, nsel};
      r = r10[8:0];
    end
  end

  assign rem_inc = rem_q + 9'd1;

  assign xs = corner_q[0] ? hi_q[0] : base_q[0];
  assign ys = corner_q[1] ? hi_q[1] : base_q[1];
  assign zs = corner_q[2] ? hi_q[2] : base_q[2];
  assign wx = corner_q[0] ? {1'b0, frac_q[0]} : cicdd_pkg::UNIT_WEIGHT - {1'b0, frac_q[0]};
  assign wy = corner_q[1] ? {1'b0, frac_q[1]} : cicdd_pkg::UNIT_WEIGHT - {1'b0, frac_q[1]};
  assign wz = corner_q[2] ? {1'b0, frac_q[2]} : cicdd_pkg::UNIT_WEIGHT - {1'b0, frac_q[2]};

  assign t        = {9'd0, ys} + p1_q;
  assign idx_full = {18'd0, xs} + {17'd0, nx} * {9'd0, t};
  assign wprod    = {17'd0, wxy_q} * {34'd0, wz};
  assign count    = {8'd0, nxy_q} * {16'd0, nz};
  assign sum      = {1'b0, rdata} + {16'd0, w_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      limit_q  <= FULL;
      axis_q   <= '0;
      step_q   <= '0;
      corner_q <= '0;
      sat_q    <= 1'b0;
    end else begin
      case (cmd_i.op)
        cicdd_pkg::OP_LOAD: begin
          axis_q   <= '0;
          corner_q <= '0;
        end
        cicdd_pkg::OP_SWEEP: begin
          cnt_q <= status_o.sweep_last ? '0 : cnt_q + 1'b1;
        end
        cicdd_pkg::OP_CLR2: begin
          sat_q <= 1'b0;
          if ({1'b0, count} > 26'(DEPTH)) limit_q <= FULL;
          else limit_q <= (CELL_INDEX_BITS+1)'(count);
        end
        cicdd_pkg::OP_MUL:  step_q   <= '0;
        cicdd_pkg::OP_MOD:  step_q   <= step_q + 3'd1;
        cicdd_pkg::OP_AXIS: axis_q   <= axis_q + 2'd1;
        cicdd_pkg::OP_CD: begin
          corner_q <= corner_q + 3'd1;
          if (sum[32]) sat_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      cicdd_pkg::OP_LOAD: begin
        pos_q[0] <= pos_x_i;
        pos_q[1] <= pos_y_i;
        pos_q[2] <= pos_z_i;
        idx_q    <= CELL_INDEX_BITS'(cell_index_i);
      end
      cicdd_pkg::OP_CLR1: nxy_q <= 17'({8'd0, nx} * {8'd0, ny});
      cicdd_pkg::OP_MUL: begin
        sh_q           <= prod[63:32];
        frac_q[axis_q] <= prod[31:16];
        rem_q          <= '0;
      end
      cicdd_pkg::OP_MOD: begin
        sh_q  <= sh;
        rem_q <= r;
      end
      cicdd_pkg::OP_AXIS: begin
        base_q[axis_q] <= rem_q[7:0];
        hi_q[axis_q]   <= (rem_inc == nsel) ? 8'd0 : rem_inc[7:0];
      end
      cicdd_pkg::OP_CA: begin
        p1_q  <= 17'({8'd0, ny} * {9'd0, zs});
        wxy_q <= {17'd0, wx} * {17'd0, wy};
      end
      cicdd_pkg::OP_CB: begin
        idx_q <= CELL_INDEX_BITS'(idx_full);
        w_q   <= wprod[48:32];
      end
      default: ;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    wdata = '0;
    addr  = idx_q;
    case (cmd_i.op)
      cicdd_pkg::OP_SWEEP: begin
        we   = 1'b1;
        addr = cnt_q[CELL_INDEX_BITS-1:0];
      end
      cicdd_pkg::OP_CD: begin
        we    = 1'b1;
        wdata = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      end
      default: ;
    endcase
  end

  cicdd_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH)
  ) u_grid (
    .clk_i  (clk_i),
    .we_i   (we),
    .addr_i (addr),
    .wdata_i(wdata),
    .rdata_o(rdata)
  );

  assign status_o.sweep_last  = (cnt_q == limit_q - 1'b1);
  assign status_o.mod_last    = (step_q == 3'(cicdd_pkg::MOD_STEPS - 1));
  assign status_o.axis_last   = (axis_q == 2'd2);
  assign status_o.corner_last = (corner_q == 3'd7);

  assign density_o   = rdata;
  assign saturated_o = sat_q;

endmodule
`default_nettype wire

[rtl/cloud_in_cell_density_deposit_unit.sv]
`default_nettype none
// Cloud-in-cell deposit onto a periodic 3D grid held in one single-ported memory.
// An item is taken when start_i is high and busy_o low; busy_o stays high until
// the item is finished. A read passes S_RD and shows its result in S_RD_OUT on
// density_o/saturated_o for one cycle with result_valid_o; the receiver cannot
// stall it. A deposit does per axis one 32x32 multiply, the 4-bit-per-cycle
// remainder unit and S_DAXIS, then per corner S_CA to S_CD for index and weight
// products and the read-modify-write of the grid memory. A clear passes S_CLR1
// and S_CLR2, then writes min(nx*ny*nz, 2**CELL_INDEX_BITS) cells, one per
// cycle. After reset a clearing pass over all 2**CELL_INDEX_BITS cells runs
// before the first item is taken; configuration writes are taken throughout.
module cloud_in_cell_density_deposit_unit #(
  parameter int CELL_INDEX_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [31:0] pos_x_i,
  input  wire logic [31:0] pos_y_i,
  input  wire logic [31:0] pos_z_i,
  input  wire logic [7:0]  color_i,
  input  wire logic [15:0] cell_index_i,
  output logic             result_valid_o,
  output logic [31:0]      density_o,
  output logic             saturated_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [8:0]  cells_x_q, cells_y_q, cells_z_q;
  logic [31:0] inv_x_q, inv_y_q, inv_z_q;
  logic        cfg_wr;

  cicdd_pkg::dp_cmd_t    cmd;
  cicdd_pkg::dp_status_t status;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cells_x_q <= 9'd16;
      cells_y_q <= 9'd16;
      cells_z_q <= 9'd16;
      inv_x_q   <= 32'd65536;
      inv_y_q   <= 32'd65536;
      inv_z_q   <= 32'd65536;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        cicdd_pkg::REG_CELLS_X: cells_x_q <= pwdata[8:0];
        cicdd_pkg::REG_CELLS_Y: cells_y_q <= pwdata[8:0];
        cicdd_pkg::REG_CELLS_Z: cells_z_q <= pwdata[8:0];
        cicdd_pkg::REG_INV_X:   inv_x_q   <= pwdata;
        cicdd_pkg::REG_INV_Y:   inv_y_q   <= pwdata;
        cicdd_pkg::REG_INV_Z:   inv_z_q   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      cicdd_pkg::REG_CELLS_X: prdata = {23'd0, cells_x_q};
      cicdd_pkg::REG_CELLS_Y: prdata = {23'd0, cells_y_q};
      cicdd_pkg::REG_CELLS_Z: prdata = {23'd0, cells_z_q};
      cicdd_pkg::REG_INV_X:   prdata = inv_x_q;
      cicdd_pkg::REG_INV_Y:   prdata = inv_y_q;
      cicdd_pkg::REG_INV_Z:   prdata = inv_z_q;
      default:                prdata = '0;
    endcase
  end

  cicdd_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .action_i      (action_i),
    .color_i       (color_i),
    .status_i      (status),
    .cmd_o         (cmd),
    .busy_o        (busy_o),
    .result_valid_o(result_valid_o)
  );

  cicdd_dp #(
    .CELL_INDEX_BITS(CELL_INDEX_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cells_x_i   (cells_x_q),
    .cells_y_i   (cells_y_q),
    .cells_z_i   (cells_z_q),
    .inv_x_i     (inv_x_q),
    .inv_y_i     (inv_y_q),
    .inv_z_i     (inv_z_q),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .pos_z_i     (pos_z_i),
    .cell_index_i(cell_index_i),
    .density_o   (density_o),
    .saturated_o (saturated_o)
  );

endmodule
`default_nettype wire

[rtl/cicdd_checker.sv]
`default_nettype none
module cicdd_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       start_i,
  input wire logic       busy_o,
  input wire logic [1:0] action_i,
  input wire logic       result_valid_o
);

  // a result is only shown while the block is still busy with the read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy_o)
    else $error("result outside of busy window");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("read gave more than one result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && action_i == cicdd_pkg::ACT_READ) |=> busy_o ##1 result_valid_o)
    else $error("read transfer did not give its result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && action_i == cicdd_pkg::ACT_CLEAR) |=> busy_o && !result_valid_o)
    else $error("clear transfer not taken up");

endmodule

bind cloud_in_cell_density_deposit_unit cicdd_checker u_chk (.*);
`default_nettype wire
